### design/hsmc_pkg.sv
// Shared widths, constants, sign helpers and types of the hex sub-spot mask classifier.
package hsmc_pkg;

    // Field widths
    localparam int TW_W     = 11;             // tile width register
    localparam int COORD_W  = 10;             // pixel column / row
    localparam int FRAC_W   = 16;             // fraction bits of the irrational abscissae
    localparam int KQ_W     = 18;             // width of the Q16 abscissa factors

    localparam int KP_Q16   = 244584;         // (2 + sqrt3) in Q16
    localparam int KM_Q16   = 17560;          // (2 - sqrt3) in Q16

    localparam int MAX_TILE_WIDTH   = 1024;   // largest tile; wider writes saturate here
    localparam int TILE_WIDTH_RESET = 64;

    // Derived internal widths
    localparam int C_W      = TW_W - 1;       // center / radius
    localparam int Q_W      = TW_W - 2;       // width / 4
    localparam int SD_W     = TW_W + 1;       // small signed differences of integer coords
    localparam int V_W      = TW_W;           // signed row / column offset from center
    localparam int U_W      = COORD_W + FRAC_W + 1; // signed Q16 column offset
    localparam int ABS_W    = TW_W + FRAC_W;  // Q16 abscissa magnitude
    localparam int OFF_W    = ABS_W + 1;      // signed Q16 abscissa minus center
    localparam int PROD_W   = V_W + OFF_W;    // pixel-dependent product
    localparam int K_W      = SD_W + OFF_W;   // geometry-only product
    localparam int ACC_W    = K_W + 2;        // three-term cross product sum
    localparam int SQ_W     = 2 * V_W;        // signed square
    localparam int CSQ_W    = 2 * C_W;        // radius squared

    localparam int NSEC          = 6;
    localparam int SETTLE_CYCLES = 3;         // depth of the geometry register chain
    localparam int SETTLE_W      = 2;
    localparam int PIPE_DEPTH    = 4;

    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 8;

    // Sector numbering (bit positions in sector_hits)
    localparam int SEC_TOP_HI  = 0;
    localparam int SEC_TOP_LO  = 1;
    localparam int SEC_BOT_HI  = 2;
    localparam int SEC_BOT_LO  = 3;
    localparam int SEC_SIDE_HI = 4;
    localparam int SEC_SIDE_LO = 5;

    typedef struct packed {
        logic pos;
        logic neg;
    } sgn_t;

    // Signs of the three cross products of one sector for one pixel
    typedef struct packed {
        sgn_t e1;
        sgn_t e2;
        sgn_t e3;
    } esgn_t;

    // Geometry derived from the tile width
    typedef struct packed {
        logic [C_W-1:0]          c;
        logic [CSQ_W-1:0]        c_sq;
        logic signed [OFF_W-1:0] d_hi;
        logic signed [OFF_W-1:0] d_lo;
        logic signed [SD_W-1:0]  w_m_t;
        logic signed [SD_W-1:0]  t_m_c;
        logic signed [SD_W-1:0]  q_m_c;
        logic signed [SD_W-1:0]  q_s;
        logic signed [K_W-1:0]   k1_hi;
        logic signed [K_W-1:0]   k1_lo;
        logic signed [K_W-1:0]   k3_hi;
        logic signed [K_W-1:0]   k3_lo;
        sgn_t                    s_wc;
        sgn_t                    s_c;
        sgn_t                    s_qt;
        sgn_t [NSEC-1:0]         f12;
        sgn_t [NSEC-1:0]         f3;
    } geom_t;

    function automatic sgn_t sgn_of(input logic signed [ACC_W-1:0] x);
        sgn_t s;
        s.neg = x[ACC_W-1];
        s.pos = !x[ACC_W-1] && (x != '0);
        return s;
    endfunction

    function automatic sgn_t sgn_mul(input sgn_t a, input sgn_t b);
        sgn_t s;
        s.pos = (a.pos && b.pos) || (a.neg && b.neg);
        s.neg = (a.pos && b.neg) || (a.neg && b.pos);
        return s;
    endfunction

    function automatic sgn_t sgn_neg(input sgn_t a);
        sgn_t s;
        s.pos = a.neg;
        s.neg = a.pos;
        return s;
    endfunction

    // Strictly opposite sides; zero never counts
    function automatic logic sgn_opp(input sgn_t a, input sgn_t b);
        return (a.pos && b.neg) || (a.neg && b.pos);
    endfunction

endpackage

### design/hsmc_cfg.sv
// Tile width register and the three-stage chain that derives the sector geometry from it.
module hsmc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hsmc_pkg::TW_W-1:0]    cfg_data,
    output hsmc_pkg::geom_t              geom,
    output logic                         settled
);
    import hsmc_pkg::*;

    logic [TW_W-1:0]     tile_width_reg, tile_width_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;

    // stage A
    logic [C_W-1:0]          c_a_reg;
    logic [Q_W-1:0]          q_a_reg;
    logic [TW_W-1:0]         t_a_reg;
    logic [TW_W-1:0]         w_a_reg;
    logic [ABS_W-1:0]        hi_a_reg;
    logic [ABS_W-1:0]        lo_a_reg;
    logic [TW_W+1:0]         w3;
    logic [KQ_W+TW_W-1:0]    hi_prod;
    logic [KQ_W+TW_W-1:0]    lo_prod;

    // stage B
    logic [C_W-1:0]          c_b_reg;
    logic [CSQ_W-1:0]        c_sq_b_reg;
    logic signed [OFF_W-1:0] d_hi_b_reg, d_lo_b_reg;
    logic signed [SD_W-1:0]  w_m_t_b_reg, t_m_c_b_reg, q_m_c_b_reg, q_s_b_reg;
    logic signed [SD_W-1:0]  w_m_c_b_reg, c_s_b_reg, q_m_t_b_reg;

    // stage C
    geom_t geom_reg, geom_next;
    sgn_t  s_dhi, s_dlo;

    assign cfg_ready = 1'b1;

    always_comb begin
        tile_width_next = tile_width_reg;
        settle_next     = settle_reg;
        if (cfg_valid) begin
            // saturate oversized widths
            if (cfg_data > TW_W'(MAX_TILE_WIDTH)) begin
                tile_width_next = TW_W'(MAX_TILE_WIDTH);
            end else begin
                tile_width_next = cfg_data;
            end
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg <= TW_W'(TILE_WIDTH_RESET);
            settle_reg     <= SETTLE_W'(SETTLE_CYCLES);
        end else begin
            tile_width_reg <= tile_width_next;
            settle_reg     <= settle_next;
        end
    end

    assign settled = (settle_reg == '0);

    // Stage A: truncated integer anchors and the Q16 abscissae
    assign w3      = (TW_W+2)'(tile_width_reg) + ((TW_W+2)'(tile_width_reg) << 1);
    assign hi_prod = (KQ_W+TW_W)'(KP_Q16) * (KQ_W+TW_W)'(tile_width_reg);
    assign lo_prod = (KQ_W+TW_W)'(KM_Q16) * (KQ_W+TW_W)'(tile_width_reg);

    always_ff @(posedge aclk) begin
        w_a_reg  <= tile_width_reg;
        c_a_reg  <= tile_width_reg[TW_W-1:1];
        q_a_reg  <= tile_width_reg[TW_W-1:2];
        t_a_reg  <= w3[TW_W+1:2];
        hi_a_reg <= hi_prod[KQ_W+TW_W-1:2];
        lo_a_reg <= lo_prod[KQ_W+TW_W-1:2];
    end

    // Stage B: offsets from the center and small differences
    always_ff @(posedge aclk) begin
        c_b_reg     <= c_a_reg;
        c_sq_b_reg  <= CSQ_W'(c_a_reg) * CSQ_W'(c_a_reg);
        d_hi_b_reg  <= signed'(OFF_W'(hi_a_reg)) - signed'(OFF_W'(c_a_reg) << FRAC_W);
        d_lo_b_reg  <= signed'(OFF_W'(lo_a_reg)) - signed'(OFF_W'(c_a_reg) << FRAC_W);
        w_m_t_b_reg <= signed'(SD_W'(w_a_reg)) - signed'(SD_W'(t_a_reg));
        t_m_c_b_reg <= signed'(SD_W'(t_a_reg)) - signed'(SD_W'(c_a_reg));
        q_m_c_b_reg <= signed'(SD_W'(q_a_reg)) - signed'(SD_W'(c_a_reg));
        q_s_b_reg   <= signed'(SD_W'(q_a_reg));
        w_m_c_b_reg <= signed'(SD_W'(w_a_reg)) - signed'(SD_W'(c_a_reg));
        c_s_b_reg   <= signed'(SD_W'(c_a_reg));
        q_m_t_b_reg <= signed'(SD_W'(q_a_reg)) - signed'(SD_W'(t_a_reg));
    end

    // Stage C: constant cross product terms and the reference side signs
    assign s_dhi = sgn_of(ACC_W'(d_hi_b_reg));
    assign s_dlo = sgn_of(ACC_W'(d_lo_b_reg));

    always_comb begin
        geom_next.c     = c_b_reg;
        geom_next.c_sq  = c_sq_b_reg;
        geom_next.d_hi  = d_hi_b_reg;
        geom_next.d_lo  = d_lo_b_reg;
        geom_next.w_m_t = w_m_t_b_reg;
        geom_next.t_m_c = t_m_c_b_reg;
        geom_next.q_m_c = q_m_c_b_reg;
        geom_next.q_s   = q_s_b_reg;
        geom_next.k1_hi = K_W'(w_m_c_b_reg) * K_W'(d_hi_b_reg);
        geom_next.k1_lo = K_W'(w_m_c_b_reg) * K_W'(d_lo_b_reg);
        geom_next.k3_hi = K_W'(c_s_b_reg) * K_W'(d_hi_b_reg);
        geom_next.k3_lo = K_W'(c_s_b_reg) * K_W'(d_lo_b_reg);
        geom_next.s_wc  = sgn_of(ACC_W'(w_m_c_b_reg));
        geom_next.s_c   = sgn_of(ACC_W'(c_s_b_reg));
        geom_next.s_qt  = sgn_of(ACC_W'(q_m_t_b_reg));

        geom_next.f12[SEC_TOP_HI]  = sgn_mul(geom_next.s_wc, s_dhi);
        geom_next.f12[SEC_TOP_LO]  = sgn_mul(geom_next.s_wc, s_dlo);
        geom_next.f12[SEC_BOT_HI]  = sgn_neg(sgn_mul(geom_next.s_c, s_dhi));
        geom_next.f12[SEC_BOT_LO]  = sgn_neg(sgn_mul(geom_next.s_c, s_dlo));
        geom_next.f12[SEC_SIDE_HI] = sgn_mul(s_dhi, geom_next.s_qt);
        geom_next.f12[SEC_SIDE_LO] = sgn_mul(s_dlo, geom_next.s_qt);
        // far anchor always sits on the mirrored side of the near one
        for (int k = 0; k < NSEC; k++) begin
            geom_next.f3[k] = sgn_neg(geom_next.f12[k]);
        end
    end

    always_ff @(posedge aclk) begin
        geom_reg <= geom_next;
    end

    assign geom = geom_reg;

endmodule

### design/hsmc_sector.sv
// Membership decision of one sector from the signs of its three cross products.
module hsmc_sector (
    input  hsmc_pkg::esgn_t e,
    input  hsmc_pkg::sgn_t  f12,
    input  hsmc_pkg::sgn_t  f3,
    input  logic            in_circ,
    output logic            hit
);
    import hsmc_pkg::*;

    logic cut_chord, cut_far, cut_near;

    // beyond the chord only the circle part counts
    assign cut_chord = sgn_opp(e.e1, f12) && !in_circ;
    assign cut_far   = sgn_opp(e.e2, f12);
    assign cut_near  = sgn_opp(e.e3, f3);
    assign hit       = !cut_chord && !cut_far && !cut_near;

endmodule

### design/hsmc_pipe.sv
// Four-stage pixel pipeline: center offsets, products, cross product sums, sector decisions.
module hsmc_pipe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hsmc_pkg::COORD_W-1:0]   in_col,
    input  logic [hsmc_pkg::COORD_W-1:0]   in_row,
    input  hsmc_pkg::geom_t                geom,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_circle,
    output logic [hsmc_pkg::NSEC-1:0]      out_hits
);
    import hsmc_pkg::*;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    // stage 1
    logic signed [U_W-1:0] u1_reg;
    logic signed [V_W-1:0] v1_reg, dx1_reg;

    // stage 2
    logic signed [PROD_W-1:0] vd2_reg, ve2_reg, uwt2_reg, utc2_reg, uqc2_reg, uq2_reg;
    logic signed [SQ_W-1:0]   dxsq, dysq;
    logic [SQ_W-2:0]          dxsq2_reg, dysq2_reg;
    sgn_t                     su2_reg, sdu2_reg, seu2_reg;

    // stage 3
    logic signed [ACC_W-1:0] e1_hi, e1_lo, e2_hi, e2_lo, e3_hi, e3_lo, eb_hi, eb_lo;
    logic [SQ_W-1:0]         sq_sum;
    esgn_t [NSEC-1:0]        es3_next, es3_reg;
    logic                    circ3_reg;

    // stage 4
    logic [NSEC-1:0] hits4_next, hits4_reg;
    logic            circ4_reg;

    // Advance a stage when it is empty or the next one takes its word
    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: offsets from the center
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            u1_reg  <= signed'(U_W'(geom.c) << FRAC_W) - signed'(U_W'(in_col) << FRAC_W);
            v1_reg  <= signed'(V_W'(in_row)) - signed'(V_W'(geom.c));
            dx1_reg <= signed'(V_W'(in_col)) - signed'(V_W'(geom.c));
        end
    end

    // Stage 2: one multiplier per product term
    assign dxsq = SQ_W'(dx1_reg) * SQ_W'(dx1_reg);
    assign dysq = SQ_W'(v1_reg) * SQ_W'(v1_reg);

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            vd2_reg   <= PROD_W'(v1_reg) * PROD_W'(geom.d_hi);
            ve2_reg   <= PROD_W'(v1_reg) * PROD_W'(geom.d_lo);
            uwt2_reg  <= PROD_W'(u1_reg) * PROD_W'(geom.w_m_t);
            utc2_reg  <= PROD_W'(u1_reg) * PROD_W'(geom.t_m_c);
            uqc2_reg  <= PROD_W'(u1_reg) * PROD_W'(geom.q_m_c);
            uq2_reg   <= PROD_W'(u1_reg) * PROD_W'(geom.q_s);
            dxsq2_reg <= dxsq[SQ_W-2:0];
            dysq2_reg <= dysq[SQ_W-2:0];
            su2_reg   <= sgn_of(ACC_W'(u1_reg));
            sdu2_reg  <= sgn_of(ACC_W'(geom.d_hi) + ACC_W'(u1_reg));
            seu2_reg  <= sgn_of(ACC_W'(geom.d_lo) + ACC_W'(u1_reg));
        end
    end

    // Stage 3: cross product sums and their signs
    assign e1_hi  = ACC_W'(geom.k1_hi) + ACC_W'(uwt2_reg) - ACC_W'(vd2_reg);
    assign e1_lo  = ACC_W'(geom.k1_lo) + ACC_W'(uwt2_reg) - ACC_W'(ve2_reg);
    assign e2_hi  = ACC_W'(vd2_reg) + ACC_W'(utc2_reg);
    assign e2_lo  = ACC_W'(ve2_reg) + ACC_W'(utc2_reg);
    assign e3_hi  = ACC_W'(vd2_reg) + ACC_W'(uqc2_reg);
    assign e3_lo  = ACC_W'(ve2_reg) + ACC_W'(uqc2_reg);
    assign eb_hi  = ACC_W'(vd2_reg) + ACC_W'(geom.k3_hi) + ACC_W'(uq2_reg);
    assign eb_lo  = ACC_W'(ve2_reg) + ACC_W'(geom.k3_lo) + ACC_W'(uq2_reg);
    assign sq_sum = SQ_W'(dxsq2_reg) + SQ_W'(dysq2_reg);

    always_comb begin
        es3_next[SEC_TOP_HI].e1  = sgn_of(e1_hi);
        es3_next[SEC_TOP_HI].e2  = sgn_of(e2_hi);
        es3_next[SEC_TOP_HI].e3  = sgn_mul(su2_reg, geom.s_wc);
        es3_next[SEC_TOP_LO].e1  = sgn_of(e1_lo);
        es3_next[SEC_TOP_LO].e2  = sgn_of(e2_lo);
        es3_next[SEC_TOP_LO].e3  = sgn_mul(su2_reg, geom.s_wc);
        es3_next[SEC_BOT_HI].e1  = sgn_neg(sgn_of(eb_hi));
        es3_next[SEC_BOT_HI].e2  = sgn_of(e3_hi);
        es3_next[SEC_BOT_HI].e3  = sgn_neg(sgn_mul(su2_reg, geom.s_c));
        es3_next[SEC_BOT_LO].e1  = sgn_neg(sgn_of(eb_lo));
        es3_next[SEC_BOT_LO].e2  = sgn_of(e3_lo);
        es3_next[SEC_BOT_LO].e3  = sgn_neg(sgn_mul(su2_reg, geom.s_c));
        es3_next[SEC_SIDE_HI].e1 = sgn_mul(sdu2_reg, geom.s_qt);
        es3_next[SEC_SIDE_HI].e2 = sgn_of(e2_hi);
        es3_next[SEC_SIDE_HI].e3 = sgn_of(e3_hi);
        es3_next[SEC_SIDE_LO].e1 = sgn_mul(seu2_reg, geom.s_qt);
        es3_next[SEC_SIDE_LO].e2 = sgn_of(e2_lo);
        es3_next[SEC_SIDE_LO].e3 = sgn_of(e3_lo);
    end

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            es3_reg   <= es3_next;
            circ3_reg <= (sq_sum <= SQ_W'(geom.c_sq));
        end
    end

    // Stage 4: sector decisions
    for (genvar k = 0; k < NSEC; k++) begin : g_sector
        hsmc_sector u_sector (
            .e       (es3_reg[k]),
            .f12     (geom.f12[k]),
            .f3      (geom.f3[k]),
            .in_circ (circ3_reg),
            .hit     (hits4_next[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (s4_ready) begin
            hits4_reg <= hits4_next;
            circ4_reg <= circ3_reg;
        end
    end

    assign out_valid  = s4_valid_reg;
    assign out_circle = circ4_reg;
    assign out_hits   = hits4_reg;

endmodule

### design/hex_subspot_mask_classifier.sv
// Top level of the hex sub-spot mask classifier: stream ports, configuration and checks.
//
// Classifies one pixel (column, row) of a square tile of side tile_width: whether it
// lies in the inscribed circle, and in which of six hexagonal sectors. One pixel is
// accepted per clock while the geometry has settled, and each result passes through a
// four-stage pipeline (center offsets, one multiplier per product term, cross product
// sums, sector decision); a stall on the result side only blocks once all four stages
// hold a word. The tile width register is written over its own valid/ready channel,
// which is always ready; writes above MAX_TILE_WIDTH saturate. The geometry derived from
// the width passes a three-register chain, so after reset and after each write s_tready
// stays low until the chain has settled. Write the width only while no pixel is in flight.
module hex_subspot_mask_classifier (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: tile_width
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hsmc_pkg::TW_W-1:0]          cfg_data,
    // pixel words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hsmc_pkg::TDATA_IN_W-1:0]    s_tdata,  // [9:0] pixel_col, [19:10] pixel_row
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hsmc_pkg::TDATA_OUT_W-1:0]   m_tdata   // [0] inside_circle, [6:1] sector_hits
);
    import hsmc_pkg::*;

    geom_t            geom;
    logic             settled;
    logic             pipe_in_ready;
    logic             res_circle;
    logic [NSEC-1:0]  res_hits;
    logic [COORD_W-1:0] pixel_col, pixel_row;

    // unpack the pixel word
    assign pixel_col = s_tdata[COORD_W-1:0];
    assign pixel_row = s_tdata[2*COORD_W-1:COORD_W];

    hsmc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .settled   (settled)
    );

    // hold off pixels until the geometry matches the register
    assign s_tready = pipe_in_ready && settled;

    hsmc_pipe u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid && settled),
        .in_ready   (pipe_in_ready),
        .in_col     (pixel_col),
        .in_row     (pixel_row),
        .geom       (geom),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_circle (res_circle),
        .out_hits   (res_hits)
    );

    // pack the result word, zero padded
    assign m_tdata = TDATA_OUT_W'({res_hits, res_circle});

`ifndef SYNTHESIS
    cfg_pause_start_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_tready)
        else $error("pixel accepted right after a width write");

    cfg_pause_end_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |-> ##SETTLE_CYCLES !s_tready)
        else $error("pixel accepted before the geometry chain settled");

    first_result_latency_a: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, PIPE_DEPTH))
        else $error("result appeared without a pixel accepted four cycles earlier");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the hex sub-spot mask classifier: pixel stream in, class words out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsmc_pkg::*;

    // Pipeline fill stall on the result side, and the no-progress limit of the watchdog.
    localparam int    RX_HOLD_CYCLES  = 400;
    localparam int    STALL_LIMIT     = 5000;
    localparam int    RANDOM_PHASES   = 12;
    localparam int    PHASE_PIXELS    = 160;
    localparam longint Q16_ONE        = 65536;

    // One expected class word: inside_circle in bit 0, sector_hits above it.
    typedef struct packed {
        logic [NSEC-1:0] hits;
        logic            in_circle;
    } pixel_class_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [TW_W-1:0]        cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;   // [9:0] pixel_col, [19:10] pixel_row
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;          // [0] inside_circle, [6:1] sector_hits

    pixel_class_t    expected_classes[$];
    logic [TW_W-1:0] width_model = TW_W'(TILE_WIDTH_RESET);

    int  burst_left      = 0;
    int  pixels_sent     = 0;
    int  results_checked = 0;
    int  width_writes    = 0;
    int  fail_count      = 0;
    bit  tx_idle_en      = 1'b1;
    bit  rx_lock         = 1'b0;
    bit  hold_req        = 1'b0;
    bit  hold_done       = 1'b0;

    hex_subspot_mask_classifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Class predictor
    // ------------------------------------------------------------------

    // Strictly opposite signs; a zero side value never counts.
    function automatic bit sides_differ(input longint a, input longint b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // Triangle center-A-B joined with the circle part inside the wedge at the center.
    // All coordinates are Q16.
    function automatic bit sector_contains(input longint px, input longint py,
                                           input longint ox, input longint oy,
                                           input longint ax, input longint ay,
                                           input longint bx, input longint by,
                                           input bit in_circ);
        longint e1, f1, e2, f2, e3, f3;
        e1 = (py - ay) * (ax - bx) + (ax - px) * (ay - by);
        f1 = (oy - ay) * (ax - bx) + (ax - ox) * (ay - by);
        if (sides_differ(e1, f1) && !in_circ)
            return 1'b0;
        e2 = (py - oy) * (bx - ox) + (ox - px) * (by - oy);
        f2 = (ay - oy) * (bx - ox) + (ox - ax) * (by - oy);
        if (sides_differ(e2, f2))
            return 1'b0;
        e3 = (py - oy) * (ax - ox) + (ox - px) * (ay - oy);
        f3 = (by - oy) * (ax - ox) + (ox - bx) * (ay - oy);
        return !sides_differ(e3, f3);
    endfunction

    function automatic pixel_class_t classify_pixel(input logic [TW_W-1:0] width,
                                                    input logic [COORD_W-1:0] col,
                                                    input logic [COORD_W-1:0] row);
        longint w, c, q, t, dx, dy, hi, lo, px, py, cq, wq, qq, tq;
        bit in_circ;
        pixel_class_t r;
        w  = longint'(width);
        c  = w / 2;
        q  = w / 4;
        t  = (3 * w) / 4;
        dx = longint'(col) - c;
        dy = longint'(row) - c;
        in_circ = (dx * dx + dy * dy) <= c * c;
        // Irrational abscissae, truncated Q16
        hi = (longint'(KP_Q16) * w) >> 2;
        lo = (longint'(KM_Q16) * w) >> 2;
        px = longint'(col) * Q16_ONE;
        py = longint'(row) * Q16_ONE;
        cq = c * Q16_ONE;
        wq = w * Q16_ONE;
        qq = q * Q16_ONE;
        tq = t * Q16_ONE;
        r.in_circle            = in_circ;
        r.hits[SEC_TOP_HI]     = sector_contains(px, py, cq, cq, cq, wq, hi, tq, in_circ);
        r.hits[SEC_TOP_LO]     = sector_contains(px, py, cq, cq, cq, wq, lo, tq, in_circ);
        r.hits[SEC_BOT_HI]     = sector_contains(px, py, cq, cq, cq, 0,  hi, qq, in_circ);
        r.hits[SEC_BOT_LO]     = sector_contains(px, py, cq, cq, cq, 0,  lo, qq, in_circ);
        r.hits[SEC_SIDE_HI]    = sector_contains(px, py, cq, cq, hi, qq, hi, tq, in_circ);
        r.hits[SEC_SIDE_LO]    = sector_contains(px, py, cq, cq, lo, qq, lo, tq, in_circ);
        return r;
    endfunction

    // Width register saturates above the largest tile.
    function automatic logic [TW_W-1:0] clamp_width(input logic [TW_W-1:0] v);
        return (v > MAX_TILE_WIDTH) ? TW_W'(MAX_TILE_WIDTH) : v;
    endfunction

    // Mostly pixels inside the tile, where the sector edges lie; some anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(input logic [TW_W-1:0] width);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            return COORD_W'($urandom_range(0, 1023));
        if (width < 2)
            return COORD_W'($urandom_range(0, 1));
        return COORD_W'($urandom_range(0, int'(width) - 1));
    endfunction

    // ------------------------------------------------------------------
    // Sender, drain and configuration
    // ------------------------------------------------------------------

    // Offer one pixel word and hold it until accepted; record its expected class.
    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        // Start a new burst, possibly after a random gap with tvalid low.
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tx_idle_en && $urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_classes.push_back(classify_pixel(width_model, col, row));
        pixels_sent++;
    endtask

    // Drop tvalid, wait for every expected word, then let the pipeline settle.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_classes.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_tile_width(input logic [TW_W-1:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        width_model = clamp_width(value);
        width_writes++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: switches between random stall patterns; one long hold on request.
    // ------------------------------------------------------------------
    int          rx_cycle  = 0;
    int          hold_left = 0;
    logic [1:0]  rx_mode   = 2'd0;

    always @(posedge aclk) begin : rx_pattern
        rx_cycle++;
        if (rx_cycle % 96 == 0)
            rx_mode = 2'($urandom_range(0, 3));
        if (hold_req && !hold_done) begin
            hold_left = RX_HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_lock) begin
            m_tready <= 1'b1;
        end else begin
            case (rx_mode)
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= (rx_cycle % 5) != 0;
                default: m_tready <= rx_cycle[3];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        pixel_class_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_classes.size() == 0) begin
                $error("result word %h arrived with no pixel pending", m_tdata);
                fail_count++;
            end else begin
                want = expected_classes.pop_front();
                if (m_tdata[0] !== want.in_circle) begin
                    $error("inside_circle: expected %0d, got %0d", want.in_circle, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[NSEC:1] !== want.hits) begin
                    $error("sector_hits: expected %b, got %b", want.hits, m_tdata[NSEC:1]);
                    fail_count++;
                end
                results_checked++;
            end
        end
    end

    // Watchdog: end the run when no word moves on any channel for too long.
    int idle_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset width of 64: corners, center, anchor points and circle edge.
    task automatic test_default_width();
        send_pixel(10'd0,    10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0,    10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd32,   10'd32);
        send_pixel(10'd32,   10'd64);
        send_pixel(10'd32,   10'd0);
        send_pixel(10'd59,   10'd48);
        send_pixel(10'd60,   10'd48);
        send_pixel(10'd4,    10'd16);
        send_pixel(10'd5,    10'd16);
        send_pixel(10'd64,   10'd32);
        send_pixel(10'd0,    10'd32);
    endtask

    // Degenerate widths, the smallest legal one and a saturating write.
    task automatic test_width_extremes();
        write_tile_width(11'd0);
        send_pixel(10'd0,    10'd0);
        send_pixel(10'd1,    10'd1);
        send_pixel(10'd1023, 10'd1023);
        write_tile_width(11'd1);
        send_pixel(10'd0,    10'd0);
        send_pixel(10'd1,    10'd0);
        send_pixel(10'd0,    10'd1);
        write_tile_width(11'd2);
        send_pixel(10'd1,    10'd1);
        send_pixel(10'd0,    10'd2);
        write_tile_width(11'd2047);
        send_pixel(10'd512,  10'd512);
        send_pixel(10'd0,    10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512,  10'd1023);
    endtask

    // Phases of random pixels, each under its own width and idling mix.
    task automatic test_random_widths();
        logic [TW_W-1:0] w;
        int sel;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       w = 11'd3;
                1:       w = 11'd1024;
                2:       w = 11'd1025;
                3:       w = 11'd0;
                4:       w = 11'd1;
                default: begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6)
                        w = TW_W'($urandom_range(2, 40));
                    else if (sel < 9)
                        w = TW_W'($urandom_range(41, 1024));
                    else
                        w = TW_W'($urandom_range(1025, 2047));
                end
            endcase
            write_tile_width(w);
            // Every fourth phase runs with no idling on either side.
            tx_idle_en = (p % 4) != 3;
            rx_lock    = (p % 4) == 3;
            repeat (PHASE_PIXELS) send_pixel(pick_coord(width_model), pick_coord(width_model));
        end
        rx_lock    = 1'b0;
        tx_idle_en = 1'b1;
    endtask

    // Hold the result side off while pixels keep coming, so the input stalls.
    task automatic test_input_backpressure();
        write_tile_width(11'd48);
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (150) send_pixel(pick_coord(width_model), pick_coord(width_model));
        tx_idle_en = 1'b1;
    endtask

    task automatic finish_run();
        drain_pipeline();
        $display("Checked %0d class words from %0d pixels over %0d width settings,",
                 results_checked, pixels_sent, width_writes + 1);
        $display("including degenerate, saturating and full widths and a %0d-cycle output stall.",
                 RX_HOLD_CYCLES);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_width();
        test_width_extremes();
        test_random_widths();
        test_input_backpressure();
        finish_run();
    end

endmodule

### files.f
design/hsmc_pkg.sv
design/hsmc_cfg.sv
design/hsmc_sector.sv
design/hsmc_pipe.sv
design/hex_subspot_mask_classifier.sv
tb/tb.sv
